### rtl/core/ar3p_pkg.sv
// Shared widths, constants, configuration and coefficient types for the point rotator.
// The CORDIC arctangent table lives here as a function. No dependencies.
package ar3p_pkg;

   localparam int COORD_WIDTH   = 32;
   localparam int ANGLE_WIDTH   = 16;
   localparam int COEF_WIDTH    = 32;
   localparam int FRAC_SHIFT    = 30;
   localparam int TURN_WIDTH    = 32;
   localparam int CORDIC_STEPS  = 30;
   localparam int STEP_WIDTH    = $clog2(CORDIC_STEPS);
   localparam int XY_WIDTH      = 34;
   localparam int Z_WIDTH       = 33;
   localparam int PROD_WIDTH    = COORD_WIDTH + COEF_WIDTH;
   localparam int SUM_WIDTH     = PROD_WIDTH + 1;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_AXIS_ADDR  = CSR_ADDR_WIDTH'(0);
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_ANGLE_ADDR = CSR_ADDR_WIDTH'(4);

   localparam logic signed [XY_WIDTH-1:0] CORDIC_GAIN = XY_WIDTH'(652032874);
   localparam logic signed [XY_WIDTH-1:0] ONE_Q30     = XY_WIDTH'(1073741824);

   typedef enum logic [1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } axis_type;

   typedef enum logic [1:0] {
      CORDIC_LOAD,
      CORDIC_RUN,
      CORDIC_MAP,
      CORDIC_IDLE
   } cordic_state_type;

   typedef struct packed {
      axis_type                axis;
      logic [ANGLE_WIDTH-1:0]  angle;
      logic                    angle_load;
   } cfg_type;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] c;
      logic signed [COEF_WIDTH-1:0] s;
      logic signed [COEF_WIDTH-1:0] ns;
   } coef_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [TURN_WIDTH-1:0] cordic_arc(input logic [STEP_WIDTH-1:0] idx);
      logic [TURN_WIDTH-1:0] arc;
      unique case (idx)
         5'd0:    arc = 32'h20000000;
         5'd1:    arc = 32'h12E4051E;
         5'd2:    arc = 32'h09FB385B;
         5'd3:    arc = 32'h051111D4;
         5'd4:    arc = 32'h028B0D43;
         5'd5:    arc = 32'h0145D7E1;
         5'd6:    arc = 32'h00A2F61E;
         5'd7:    arc = 32'h00517C55;
         5'd8:    arc = 32'h0028BE53;
         5'd9:    arc = 32'h00145F2F;
         5'd10:   arc = 32'h000A2F98;
         5'd11:   arc = 32'h000517CC;
         5'd12:   arc = 32'h00028BE6;
         5'd13:   arc = 32'h000145F3;
         5'd14:   arc = 32'h0000A2F9;
         5'd15:   arc = 32'h0000517C;
         5'd16:   arc = 32'h000028BE;
         5'd17:   arc = 32'h0000145F;
         5'd18:   arc = 32'h00000A2F;
         5'd19:   arc = 32'h00000517;
         5'd20:   arc = 32'h0000028B;
         5'd21:   arc = 32'h00000145;
         5'd22:   arc = 32'h000000A2;
         5'd23:   arc = 32'h00000051;
         5'd24:   arc = 32'h00000028;
         5'd25:   arc = 32'h00000014;
         5'd26:   arc = 32'h0000000A;
         5'd27:   arc = 32'h00000005;
         5'd28:   arc = 32'h00000002;
         5'd29:   arc = 32'h00000001;
         default: arc = '0;
      endcase
      return arc;
   endfunction

endpackage

### rtl/core/axis_rotate_3d_point.sv
// Top level of the 3-D point rotator: register file, sine/cosine unit, point pipeline.
// Depends on ar3p_pkg, ar3p_csr, ar3p_cordic and ar3p_rot_pipe.
//
// Rotates a signed Q16.16 point about the X, Y or Z axis (axis code 3 passes it through) by
// a binary angle, with Q2.30 sine and cosine, round half up and saturation. One point is
// accepted per cycle while req_stall is low, and its result reaches the rsp_ ports through
// four register stages (capture, multiply, sum, saturate). Sine and cosine come from an
// iterative CORDIC that runs after reset and after every angle write; req_stall is held
// high while it runs. Axis writes take effect at once.
module axis_rotate_3d_point import ar3p_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]     paddr,
   input  logic [CSR_DATA_WIDTH-1:0]     pwdata,
   output logic [CSR_DATA_WIDTH-1:0]     prdata,
   output logic                          pready,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_x_in,
   input  logic signed [COORD_WIDTH-1:0] req_y_in,
   input  logic signed [COORD_WIDTH-1:0] req_z_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_x_out,
   output logic signed [COORD_WIDTH-1:0] rsp_y_out,
   output logic signed [COORD_WIDTH-1:0] rsp_z_out
);

   cfg_type  cfg;
   coef_type coef;
   logic     busy;

   ar3p_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ar3p_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .coef  (coef),
      .busy  (busy)
   );

   ar3p_rot_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .axis      (cfg.axis),
      .coef      (coef),
      .hold      (busy),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_x_in  (req_x_in),
      .req_y_in  (req_y_in),
      .req_z_in  (req_z_in),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_x_out (rsp_x_out),
      .rsp_y_out (rsp_y_out),
      .rsp_z_out (rsp_z_out)
   );

   a_no_transfer_while_busy: assert property (
      @(posedge clock) disable iff (reset) busy |-> req_stall)
      else $error("input transfer possible while sine/cosine unit is busy");

   a_angle_write_restarts: assert property (
      @(posedge clock) disable iff (reset) cfg.angle_load |=> busy)
      else $error("angle write did not restart sine/cosine unit");

   a_busy_after_reset: assert property (
      @(posedge clock) $fell(reset) |-> busy)
      else $error("sine/cosine unit not running after reset");

endmodule

### rtl/core/ar3p_csr.sv
// APB-style register file: rotation axis and rotation angle.
// Depends on ar3p_pkg.
module ar3p_csr import ar3p_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [CSR_DATA_WIDTH-1:0]  prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   axis_type                axis_ff, axis_in;
   logic [ANGLE_WIDTH-1:0]  angle_ff, angle_in;
   logic                    wr_en;
   logic                    sel_angle;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign sel_angle = paddr[2];

   always_comb begin
      axis_in  = axis_ff;
      angle_in = angle_ff;
      if (wr_en && !sel_angle) begin
         axis_in = axis_type'(pwdata[1:0]);
      end
      if (wr_en && sel_angle) begin
         angle_in = pwdata[ANGLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff  <= AXIS_X;
         angle_ff <= '0;
      end else begin
         axis_ff  <= axis_in;
         angle_ff <= angle_in;
      end
   end

   always_comb begin
      if (sel_angle) begin
         prdata = CSR_DATA_WIDTH'(angle_ff);
      end else begin
         prdata = CSR_DATA_WIDTH'(axis_ff);
      end
   end

   assign cfg.axis       = axis_ff;
   assign cfg.angle      = angle_ff;
   assign cfg.angle_load = wr_en && sel_angle;

endmodule

### rtl/core/ar3p_cordic.sv
// Iterative CORDIC: one micro-rotation per cycle, then quadrant fold and clamp to Q2.30.
// Recomputes after reset and after every angle write. Depends on ar3p_pkg.
module ar3p_cordic import ar3p_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   output coef_type coef,
   output logic     busy
);

   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(CORDIC_STEPS - 1);

   cordic_state_type              state_ff, state_in;
   logic [STEP_WIDTH-1:0]         step_ff, step_in;
   logic [1:0]                    quad_ff, quad_in;
   logic signed [XY_WIDTH-1:0]    x_ff, x_in;
   logic signed [XY_WIDTH-1:0]    y_ff, y_in;
   logic signed [Z_WIDTH-1:0]     z_ff, z_in;
   coef_type                      coef_ff, coef_in;
   logic signed [XY_WIDTH-1:0]    x_sh, y_sh;
   logic signed [Z_WIDTH-1:0]     arc;
   logic signed [XY_WIDTH-1:0]    c_raw, s_raw, c_clamp, s_clamp;
   logic                          do_load, do_step, do_map;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CORDIC_LOAD: state_in = CORDIC_RUN;
         CORDIC_RUN:  state_in = (step_ff == LAST_STEP) ? CORDIC_MAP : CORDIC_RUN;
         CORDIC_MAP:  state_in = CORDIC_IDLE;
         CORDIC_IDLE: state_in = CORDIC_IDLE;
         default:     state_in = CORDIC_LOAD;
      endcase
      if (cfg.angle_load) begin
         state_in = CORDIC_LOAD;
      end
   end

   always_comb begin
      do_load = 1'b0;
      do_step = 1'b0;
      do_map  = 1'b0;
      busy    = 1'b1;
      unique case (state_ff)
         CORDIC_LOAD: do_load = 1'b1;
         CORDIC_RUN:  do_step = 1'b1;
         CORDIC_MAP:  do_map  = 1'b1;
         CORDIC_IDLE: busy    = 1'b0;
         default:     busy    = 1'b1;
      endcase
   end

   assign x_sh = x_ff >>> step_ff;
   assign y_sh = y_ff >>> step_ff;
   assign arc  = Z_WIDTH'(cordic_arc(step_ff));

   always_comb begin
      case (quad_ff)
         2'd0:    begin c_raw = x_ff;  s_raw = y_ff;  end
         2'd1:    begin c_raw = -y_ff; s_raw = x_ff;  end
         2'd2:    begin c_raw = -x_ff; s_raw = -y_ff; end
         default: begin c_raw = y_ff;  s_raw = -x_ff; end
      endcase
      c_clamp = c_raw;
      s_clamp = s_raw;
      if (c_raw > ONE_Q30)  c_clamp = ONE_Q30;
      if (c_raw < -ONE_Q30) c_clamp = -ONE_Q30;
      if (s_raw > ONE_Q30)  s_clamp = ONE_Q30;
      if (s_raw < -ONE_Q30) s_clamp = -ONE_Q30;
   end

   always_comb begin
      step_in = step_ff;
      quad_in = quad_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      coef_in = coef_ff;
      if (do_load) begin
         step_in = '0;
         quad_in = cfg.angle[ANGLE_WIDTH-1 -: 2];
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = Z_WIDTH'({cfg.angle[ANGLE_WIDTH-3:0], {(TURN_WIDTH-ANGLE_WIDTH){1'b0}}});
      end
      if (do_step) begin
         step_in = step_ff + STEP_WIDTH'(1);
         if (!z_ff[Z_WIDTH-1]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - arc;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + arc;
         end
      end
      if (do_map) begin
         coef_in.c  = COEF_WIDTH'(c_clamp);
         coef_in.s  = COEF_WIDTH'(s_clamp);
         coef_in.ns = COEF_WIDTH'(-s_clamp);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORDIC_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quad_ff <= quad_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      coef_ff <= coef_in;
   end

   assign coef = coef_ff;

endmodule

### rtl/core/ar3p_rot_pipe.sv
// Four-stage point pipeline: capture, operand select and multiply, sum with rounding,
// shift and saturate. Depends on ar3p_pkg.
module ar3p_rot_pipe import ar3p_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  axis_type                      axis,
   input  coef_type                      coef,
   input  logic                          hold,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_x_in,
   input  logic signed [COORD_WIDTH-1:0] req_y_in,
   input  logic signed [COORD_WIDTH-1:0] req_z_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_x_out,
   output logic signed [COORD_WIDTH-1:0] rsp_y_out,
   output logic signed [COORD_WIDTH-1:0] rsp_z_out
);

   localparam logic signed [SUM_WIDTH-1:0] ROUND_HALF = SUM_WIDTH'(1) <<< (FRAC_SHIFT - 1);
   localparam logic signed [SUM_WIDTH-1:0] SAT_MAX =
      SUM_WIDTH'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam logic signed [SUM_WIDTH-1:0] SAT_MIN = -SAT_MAX - SUM_WIDTH'(1);

   function automatic logic signed [COORD_WIDTH-1:0] sat_round(
      input logic signed [SUM_WIDTH-1:0] sum);
      logic signed [SUM_WIDTH-1:0] q;
      q = sum >>> FRAC_SHIFT;
      if (q > SAT_MAX) q = SAT_MAX;
      if (q < SAT_MIN) q = SAT_MIN;
      return COORD_WIDTH'(q);
   endfunction

   logic rdy1, rdy2, rdy3, rdy4, accept;

   logic                          v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [COORD_WIDTH-1:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic signed [COORD_WIDTH-1:0] s2_x_ff, s2_y_ff, s2_z_ff;
   logic signed [COORD_WIDTH-1:0] s3_x_ff, s3_y_ff, s3_z_ff;
   logic signed [PROD_WIDTH-1:0]  pua_ff, pub_ff, pva_ff, pvb_ff;
   logic signed [PROD_WIDTH-1:0]  pua_in, pub_in, pva_in, pvb_in;
   logic signed [SUM_WIDTH-1:0]   su_ff, sv_ff, su_in, sv_in;
   logic signed [COORD_WIDTH-1:0] ox_ff, oy_ff, oz_ff, ox_in, oy_in, oz_in;
   logic signed [COORD_WIDTH-1:0] op_a, op_b, mix_u, mix_v;
   logic signed [COEF_WIDTH-1:0]  t_u, p_v;

   assign rdy4      = !v4_ff || !rsp_stall;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1 || hold;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      op_a = (axis == AXIS_X) ? s1_y_ff : s1_x_ff;
      op_b = (axis == AXIS_Z) ? s1_y_ff : s1_z_ff;
      t_u  = (axis == AXIS_Y) ? coef.s  : coef.ns;
      p_v  = (axis == AXIS_Y) ? coef.ns : coef.s;
      pua_in = PROD_WIDTH'(op_a) * PROD_WIDTH'(coef.c);
      pub_in = PROD_WIDTH'(op_b) * PROD_WIDTH'(t_u);
      pva_in = PROD_WIDTH'(op_a) * PROD_WIDTH'(p_v);
      pvb_in = PROD_WIDTH'(op_b) * PROD_WIDTH'(coef.c);
   end

   assign su_in = SUM_WIDTH'(pua_ff) + SUM_WIDTH'(pub_ff) + ROUND_HALF;
   assign sv_in = SUM_WIDTH'(pva_ff) + SUM_WIDTH'(pvb_ff) + ROUND_HALF;

   assign mix_u = sat_round(su_ff);
   assign mix_v = sat_round(sv_ff);

   always_comb begin
      ox_in = s3_x_ff;
      oy_in = s3_y_ff;
      oz_in = s3_z_ff;
      case (axis)
         AXIS_X:  begin oy_in = mix_u; oz_in = mix_v; end
         AXIS_Y:  begin ox_in = mix_u; oz_in = mix_v; end
         AXIS_Z:  begin ox_in = mix_u; oy_in = mix_v; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= accept;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_x_ff <= req_x_in;
         s1_y_ff <= req_y_in;
         s1_z_ff <= req_z_in;
      end
      if (rdy2) begin
         s2_x_ff <= s1_x_ff;
         s2_y_ff <= s1_y_ff;
         s2_z_ff <= s1_z_ff;
         pua_ff  <= pua_in;
         pub_ff  <= pub_in;
         pva_ff  <= pva_in;
         pvb_ff  <= pvb_in;
      end
      if (rdy3) begin
         s3_x_ff <= s2_x_ff;
         s3_y_ff <= s2_y_ff;
         s3_z_ff <= s2_z_ff;
         su_ff   <= su_in;
         sv_ff   <= sv_in;
      end
      if (rdy4) begin
         ox_ff <= ox_in;
         oy_ff <= oy_in;
         oz_ff <= oz_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_x_out = ox_ff;
   assign rsp_y_out = oy_ff;
   assign rsp_z_out = oz_ff;

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for axis_rotate_3d_point: predicts every rotated point with its own
// CORDIC and saturating mixer, then checks each result transfer field by field.
// Depends on ar3p_pkg and the axis_rotate_3d_point RTL.
module tb_top;
   import ar3p_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 12;
   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = 32'sh8000_0000;
   localparam longint CORDIC_START = 652032874;
   localparam longint UNIT_Q30 = 64'sd1073741824;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
   } rotated_point_type;

   logic clock;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic pready;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COORD_WIDTH-1:0] req_x_in = '0;
   logic signed [COORD_WIDTH-1:0] req_y_in = '0;
   logic signed [COORD_WIDTH-1:0] req_z_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [COORD_WIDTH-1:0] rsp_x_out;
   logic signed [COORD_WIDTH-1:0] rsp_y_out;
   logic signed [COORD_WIDTH-1:0] rsp_z_out;

   axis_rotate_3d_point uut (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_x_in(req_x_in), .req_y_in(req_y_in), .req_z_in(req_z_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_x_out(rsp_x_out), .rsp_y_out(rsp_y_out), .rsp_z_out(rsp_z_out)
   );

   longint atan_turn [0:29] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
      64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
      64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
   };

   axis_type cur_axis = AXIS_X;
   logic [ANGLE_WIDTH-1:0] cur_angle = '0;
   longint cos_q30;
   longint sin_q30;

   rotated_point_type points_due[$];
   int errors = 0;
   int points_checked = 0;
   int settings_count = 0;
   int cycles = 0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int stall_hold = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   function automatic int pick_gap(input bit nonzero);
      int r;
      r = $urandom_range(0, 99);
      if (r < 70 && !nonzero)
         return 0;
      else if (r < 95)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   function automatic void cordic_sincos(input logic [ANGLE_WIDTH-1:0] ang,
                                         output longint c, output longint s);
      logic [31:0] turn;
      longint xr, yr, zr, nx, ny;
      turn = {ang, {(32 - ANGLE_WIDTH){1'b0}}};
      zr = turn & 32'h3FFF_FFFF;
      xr = CORDIC_START;
      yr = 0;
      for (int i = 0; i < 30; i++) begin
         if (zr >= 0) begin
            nx = xr - (yr >>> i);
            ny = yr + (xr >>> i);
            zr = zr - atan_turn[i];
         end else begin
            nx = xr + (yr >>> i);
            ny = yr - (xr >>> i);
            zr = zr + atan_turn[i];
         end
         xr = nx;
         yr = ny;
      end
      case (turn[31:30])
         2'd0: begin c = xr; s = yr; end
         2'd1: begin c = -yr; s = xr; end
         2'd2: begin c = -xr; s = -yr; end
         default: begin c = yr; s = -xr; end
      endcase
      if (c > UNIT_Q30) c = UNIT_Q30;
      if (c < -UNIT_Q30) c = -UNIT_Q30;
      if (s > UNIT_Q30) s = UNIT_Q30;
      if (s < -UNIT_Q30) s = -UNIT_Q30;
   endfunction

   // round half up at 30 fraction bits, then saturate
   function automatic logic signed [COORD_WIDTH-1:0] mix_q30(input longint a, input longint p,
                                                             input longint b, input longint q);
      longint acc;
      acc = (a * p + b * q + (64'sd1 <<< 29)) >>> 30;
      if (acc > longint'(COORD_MAX)) acc = longint'(COORD_MAX);
      if (acc < longint'(COORD_MIN)) acc = longint'(COORD_MIN);
      return acc[COORD_WIDTH-1:0];
   endfunction

   function automatic rotated_point_type rotate_point(input logic signed [COORD_WIDTH-1:0] x,
                                                      input logic signed [COORD_WIDTH-1:0] y,
                                                      input logic signed [COORD_WIDTH-1:0] z);
      rotated_point_type r;
      longint lx, ly, lz;
      lx = x;
      ly = y;
      lz = z;
      r.x = x;
      r.y = y;
      r.z = z;
      case (cur_axis)
         AXIS_X: begin
            r.y = mix_q30(ly, cos_q30, lz, -sin_q30);
            r.z = mix_q30(ly, sin_q30, lz, cos_q30);
         end
         AXIS_Y: begin
            r.x = mix_q30(lx, cos_q30, lz, sin_q30);
            r.z = mix_q30(lx, -sin_q30, lz, cos_q30);
         end
         AXIS_Z: begin
            r.x = mix_q30(lx, cos_q30, ly, -sin_q30);
            r.y = mix_q30(lx, sin_q30, ly, cos_q30);
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            default: return -1;
         endcase
      end else if (r <= 3)
         return $signed($urandom_range(0, 200 << 16)) - (100 << 16);
      else
         return $urandom;
   endfunction

   // one point per call; returns at the edge where the transfer happens
   task automatic send_point(input logic signed [COORD_WIDTH-1:0] x,
                             input logic signed [COORD_WIDTH-1:0] y,
                             input logic signed [COORD_WIDTH-1:0] z);
      int gap;
      gap = req_idle_on ? pick_gap(1'b0) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_in <= x;
      req_y_in <= y;
      req_z_in <= z;
      do @(posedge clock); while (req_stall);
      points_due.push_back(rotate_point(x, y, z));
   endtask

   task automatic settle_idle();
      req_valid <= 1'b0;
      while (points_due.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_WIDTH-1:0] addr, input logic [31:0] data);
      logic [CSR_DATA_WIDTH-1:0] rd_expect;
      settle_idle();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      rd_expect = '0;
      if (addr == CSR_AXIS_ADDR) begin
         cur_axis = axis_type'(data[1:0]);
         rd_expect = CSR_DATA_WIDTH'(data[1:0]);
      end else if (addr == CSR_ANGLE_ADDR) begin
         cur_angle = data[ANGLE_WIDTH-1:0];
         rd_expect = CSR_DATA_WIDTH'(data[ANGLE_WIDTH-1:0]);
         cordic_sincos(cur_angle, cos_q30, sin_q30);
      end
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== rd_expect) begin
         $error("prdata: expected %0h, got %0h", rd_expect, prdata);
         errors++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      settings_count++;
   endtask

   task automatic set_rotation(input axis_type a, input logic [ANGLE_WIDTH-1:0] ang);
      csr_write(CSR_AXIS_ADDR, ($urandom & 32'hFFFF_FFFC) | 32'(a));
      csr_write(CSR_ANGLE_ADDR, ($urandom & 32'hFFFF_0000) | 32'(ang));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold > 0) begin
         rsp_stall <= 1'b1;
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (rsp_idle_on && $urandom_range(0, 99) < 25)
            stall_hold <= pick_gap(1'b1);
      end
   end

   always @(posedge clock) begin
      rotated_point_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (points_due.size() == 0) begin
            $error("result transfer with nothing expected: x %0d y %0d z %0d",
                   rsp_x_out, rsp_y_out, rsp_z_out);
            errors++;
         end else begin
            due = points_due.pop_front();
            points_checked++;
            if (rsp_x_out !== due.x) begin
               $error("x_out: expected %0d, got %0d", due.x, rsp_x_out);
               errors++;
            end
            if (rsp_y_out !== due.y) begin
               $error("y_out: expected %0d, got %0d", due.y, rsp_y_out);
               errors++;
            end
            if (rsp_z_out !== due.z) begin
               $error("z_out: expected %0d, got %0d", due.z, rsp_z_out);
               errors++;
            end
         end
      end
   end

   task automatic test_reset_state();
      send_point(COORD_MAX, COORD_MIN, COORD_MAX);
      send_point('0, -1, 1);
      send_point(32'sh0001_0000, COORD_MIN, '0);
   endtask

   task automatic test_pass_through();
      set_rotation(AXIS_NONE, 16'h3000);
      send_point(COORD_MIN, COORD_MAX, -1);
      send_point(32'sh1234_5678, -32'sh1234, 32'sh7FFF_0000);
   endtask

   task automatic test_saturation();
      set_rotation(AXIS_Z, 16'h2000);
      send_point(COORD_MAX, COORD_MAX, '0);
      send_point(COORD_MIN, COORD_MIN, COORD_MAX);
      send_point(COORD_MAX, COORD_MIN, COORD_MIN);
      set_rotation(AXIS_X, 16'h2000);
      send_point('0, COORD_MAX, COORD_MIN);
      set_rotation(AXIS_Y, 16'h2000);
      send_point(COORD_MIN, '0, COORD_MAX);
   endtask

   task automatic test_quadrants();
      logic [ANGLE_WIDTH-1:0] angles [5] = '{16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h0001};
      foreach (angles[i]) begin
         set_rotation(AXIS_Y, angles[i]);
         send_point(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);
      end
   endtask

   task automatic test_register_masking();
      csr_write(CSR_AXIS_ADDR, 32'hFFFF_FFF6);
      csr_write(CSR_ANGLE_ADDR, 32'hDEAD_1234);
      send_point(32'sh0100_0000, -32'sh0080_0000, 32'sh0000_0001);
      send_point(-32'sh0001_8000, 32'sh7FFF_FFFF, COORD_MIN);
   endtask

   task automatic test_random_phases();
      logic [ANGLE_WIDTH-1:0] special [6] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000,
                                              16'hC000, 16'h2000};
      logic [ANGLE_WIDTH-1:0] ang;
      int count;
      for (int phase = 0; phase < 16; phase++) begin
         ang = (phase < 6) ? special[phase] : ANGLE_WIDTH'($urandom);
         set_rotation(axis_type'(phase % 4), ang);
         req_idle_on = (phase % 5 != 0);
         rsp_idle_on = (phase % 5 != 0);
         count = $urandom_range(95, 115);
         repeat (count) send_point(rand_coord(), rand_coord(), rand_coord());
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      cordic_sincos(cur_angle, cos_q30, sin_q30);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_pass_through();
      test_saturation();
      test_quadrants();
      test_register_masking();
      test_random_phases();
      req_valid <= 1'b0;
      while (points_due.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (points_due.size() != 0) begin
         $error("%0d results never arrived", points_due.size());
         errors++;
      end
      $display("tb_top: %0d rotated points compared across %0d register writes,",
               points_checked, settings_count);
      $display("tb_top: all four axis codes, quadrant and saturation corners included");
      if (errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

### axis_rotate_3d_point.f
rtl/core/ar3p_pkg.sv
rtl/core/ar3p_csr.sv
rtl/core/ar3p_cordic.sv
rtl/core/ar3p_rot_pipe.sv
rtl/core/axis_rotate_3d_point.sv
tb/sv/tb_top.sv
